// ===== sv/sefr_pkg.sv =====
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types, register indexes and the microprogram of the frame receiver.
// ----------------------------------------------------------------------------
package sefr_pkg;

  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StIdle  = 4'd0;
  localparam step_t StStart = 4'd1;
  localparam step_t StType  = 4'd2;
  localparam step_t StZeroA = 4'd3;
  localparam step_t StZeroB = 4'd4;
  localparam step_t StEnd   = 4'd5;
  localparam step_t StRead  = 4'd6;
  localparam step_t StPay   = 4'd7;
  localparam step_t StDone  = 4'd8;
  localparam step_t StEmpty = 4'd9;

  localparam logic [2:0] RegStart    = 3'd0;
  localparam logic [2:0] RegEnd      = 3'd1;
  localparam logic [2:0] RegTypeMsg  = 3'd2;
  localparam logic [2:0] RegTypeAck  = 3'd3;
  localparam logic [2:0] RegTypeDreq = 3'd4;
  localparam logic [2:0] RegTypeDrsp = 3'd5;
  localparam logic [2:0] RegLimit    = 3'd6;

  typedef enum logic [2:0] {
    SrcNone, SrcStart, SrcType, SrcZero, SrcEnd, SrcEmpty, SrcPayload
  } src_e;

  typedef enum logic [1:0] {LastNo, LastYes, LastDisc, LastFinal} last_e;

  typedef enum logic [2:0] {
    JmpNever, JmpAlways, JmpNoResp, JmpDisc, JmpEmpty, JmpMore
  } cond_e;

  typedef struct packed {
    logic  take;
    logic  emit;
    logic  inc;
    src_e  src;
    last_e last;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic resp;
    logic disc;
    logic empty;
    logic more;
    logic slot_free;
  } stat_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] type_message;
    logic [7:0] type_acknowledge;
    logic [7:0] type_discovery_request;
    logic [7:0] type_discovery_response;
    logic [5:0] payload_limit;
  } cfg_t;

  function automatic uword_t ucode(step_t step);
    uword_t w;
    w = '{take: 1'b0, emit: 1'b0, inc: 1'b0, src: SrcNone, last: LastNo,
          cond: JmpAlways, target: StIdle};
    unique case (step)
      StIdle: begin
        w.take = 1'b1;
        w.cond = JmpNoResp;
      end
      StStart: begin
        w.emit = 1'b1;
        w.src  = SrcStart;
        w.cond = JmpNever;
      end
      StType: begin
        w.emit = 1'b1;
        w.src  = SrcType;
        w.cond = JmpNever;
      end
      StZeroA, StZeroB: begin
        w.emit = 1'b1;
        w.src  = SrcZero;
        w.cond = JmpNever;
      end
      StEnd: begin
        w.emit = 1'b1;
        w.src  = SrcEnd;
        w.last = LastDisc;
        w.cond = JmpDisc;
      end
      StRead: begin
        w.cond   = JmpEmpty;
        w.target = StEmpty;
      end
      StPay: begin
        w.emit   = 1'b1;
        w.inc    = 1'b1;
        w.src    = SrcPayload;
        w.last   = LastFinal;
        w.cond   = JmpMore;
        w.target = StRead;
      end
      StEmpty: begin
        w.emit = 1'b1;
        w.src  = SrcEmpty;
        w.last = LastYes;
      end
      default: begin
        w.cond = JmpAlways;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/sefr_seq.sv =====
// ----------------------------------------------------------------------------
// sefr_seq
// Step counter and microprogram lookup with conditional jumps.
// ----------------------------------------------------------------------------
module sefr_seq
  import sefr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stat_t  stat_i,
  output uword_t uw_o
);

  step_t  step_q, step_d;
  uword_t uw;
  logic   adv;
  logic   jump;

  assign uw   = ucode(step_q);
  assign uw_o = uw;

  always_comb begin
    if (uw.take) begin
      adv = stat_i.accept;
    end else if (uw.emit) begin
      adv = stat_i.slot_free;
    end else begin
      adv = 1'b1;
    end
    unique case (uw.cond)
      JmpNever:  jump = 1'b0;
      JmpAlways: jump = 1'b1;
      JmpNoResp: jump = !stat_i.resp;
      JmpDisc:   jump = stat_i.disc;
      JmpEmpty:  jump = stat_i.empty;
      JmpMore:   jump = stat_i.more;
      default:   jump = 1'b1;
    endcase
    if (!adv) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = uw.target;
    end else begin
      step_d = step_t'(step_q + step_t'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== sv/sefr_dp.sv =====
// ----------------------------------------------------------------------------
// sefr_dp
// Frame parser, payload store and output register driven by the microprogram.
// ----------------------------------------------------------------------------
module sefr_dp
  import sefr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  uword_t     uw_i,
  output stat_t      stat_o,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] msg_id_o,
  output logic [5:0] msg_size_o,
  output logic [4:0] payload_index_o,
  output logic [7:0] payload_byte_o,
  output logic       has_payload_o,
  output logic       last_o
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MaxP = 8'(MAX_PAYLOAD);

  typedef enum logic [1:0] {PsHunt, PsHeader, PsPayload, PsEnd} pstate_e;

  pstate_e    pst_q, pst_d;
  logic [5:0] cnt_q, cnt_d;
  logic [7:0] ftype_q, fid_q;
  logic [5:0] fsize_q;
  logic       disc_q, empty_q;
  logic [5:0] idx_q;

  logic       out_valid_q;
  logic       kind_q, has_q, last_q;
  logic [7:0] tx_q, id_q, pb_q;
  logic [5:0] size_q;
  logic [4:0] pidx_q;

  logic       kind_d, has_d, last_d;
  logic [7:0] tx_d, id_d, pb_d;
  logic [5:0] size_d;
  logic [4:0] pidx_d;

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rdata_q;

  logic          accept, load, slot_free;
  logic [5:0]    limit, nread, idx_inc, cnt_inc;
  logic          more, resp, mem_we;
  logic [7:0]    cnt_ext, idx_ext;
  logic [AW-1:0] wr_addr, rd_addr;

  assign accept    = in_valid_i && uw_i.take;
  assign in_stall_o = !uw_i.take;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load      = uw_i.emit && slot_free;

  assign limit   = ({2'b00, cfg_i.payload_limit} > MaxP) ? 6'(MAX_PAYLOAD)
                                                        : cfg_i.payload_limit;
  assign nread   = ({2'b00, fsize_q} > MaxP) ? 6'(MAX_PAYLOAD) : fsize_q;
  assign idx_inc = 6'(idx_q + 6'd1);
  assign cnt_inc = 6'(cnt_q + 6'd1);
  assign more    = idx_inc < nread;
  assign resp    = (pst_q == PsEnd) && (rx_byte_i == cfg_i.end_byte) &&
                   ((ftype_q == cfg_i.type_discovery_request) ||
                    (ftype_q == cfg_i.type_message));

  assign cnt_ext = {2'b00, cnt_q};
  assign idx_ext = {2'b00, idx_q};
  assign wr_addr = cnt_ext[AW-1:0];
  assign rd_addr = idx_ext[AW-1:0];
  assign mem_we  = accept && (pst_q == PsPayload) && (cnt_ext < MaxP);

  assign stat_o = '{accept: accept, resp: resp, disc: disc_q, empty: empty_q,
                    more: more, slot_free: slot_free};

  always_comb begin
    pst_d = pst_q;
    cnt_d = cnt_q;
    unique case (pst_q)
      PsHunt: begin
        if (rx_byte_i == cfg_i.start_byte) begin
          pst_d = PsHeader;
          cnt_d = 6'd0;
        end
      end
      PsHeader: begin
        if (cnt_q == 6'd0) begin
          cnt_d = 6'd1;
        end else if (cnt_q == 6'd1) begin
          cnt_d = 6'd2;
        end else begin
          cnt_d = 6'd0;
          if (rx_byte_i == 8'd0) begin
            pst_d = PsEnd;
          end else if (rx_byte_i <= {2'b00, limit}) begin
            pst_d = PsPayload;
          end else begin
            pst_d = PsHunt;
          end
        end
      end
      PsPayload: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= fsize_q) begin
          pst_d = PsEnd;
        end
      end
      PsEnd: begin
        pst_d = PsHunt;
        cnt_d = 6'd0;
      end
      default: begin
        pst_d = PsHunt;
        cnt_d = 6'd0;
      end
    endcase
  end

  always_comb begin
    kind_d = 1'b0;
    tx_d   = 8'd0;
    id_d   = 8'd0;
    size_d = 6'd0;
    pidx_d = 5'd0;
    pb_d   = 8'd0;
    has_d  = 1'b0;
    case (uw_i.src)
      SrcStart: tx_d = cfg_i.start_byte;
      SrcType:  tx_d = disc_q ? cfg_i.type_discovery_response
                              : cfg_i.type_acknowledge;
      SrcEnd:   tx_d = cfg_i.end_byte;
      SrcEmpty: begin
        kind_d = 1'b1;
        id_d   = fid_q;
      end
      SrcPayload: begin
        kind_d = 1'b1;
        id_d   = fid_q;
        size_d = fsize_q;
        pidx_d = idx_q[4:0];
        pb_d   = rdata_q;
        has_d  = 1'b1;
      end
      default: tx_d = 8'd0;
    endcase
    case (uw_i.last)
      LastYes:   last_d = 1'b1;
      LastDisc:  last_d = disc_q;
      LastFinal: last_d = !more;
      default:   last_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= rx_byte_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q       <= PsHunt;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pst_q <= pst_d;
        cnt_q <= cnt_d;
        if (pst_q == PsHeader) begin
          if (cnt_q == 6'd0) begin
            ftype_q <= rx_byte_i;
          end else if (cnt_q == 6'd1) begin
            fid_q <= rx_byte_i;
          end else if (rx_byte_i <= {2'b00, limit}) begin
            fsize_q <= rx_byte_i[5:0];
          end
        end
        if (pst_q == PsEnd) begin
          disc_q  <= (ftype_q == cfg_i.type_discovery_request);
          empty_q <= (fsize_q == 6'd0);
          idx_q   <= 6'd0;
        end
      end
      if (load && uw_i.inc) begin
        idx_q <= idx_inc;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        kind_q      <= kind_d;
        tx_q        <= tx_d;
        id_q        <= id_d;
        size_q      <= size_d;
        pidx_q      <= pidx_d;
        pb_q        <= pb_d;
        has_q       <= has_d;
        last_q      <= last_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = kind_q;
  assign tx_byte_o       = tx_q;
  assign msg_id_o        = id_q;
  assign msg_size_o      = size_q;
  assign payload_index_o = pidx_q;
  assign payload_byte_o  = pb_q;
  assign has_payload_o   = has_q;
  assign last_o          = last_q;

endmodule

// ===== sv/stx_etx_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_top
// Start/end delimited frame receiver with response and message delivery.
// ----------------------------------------------------------------------------
// Received bytes are taken only while the sequencer sits in its idle step.
// The end byte of a discovery-request frame then starts the response frame
// (start, type, two zero bytes and end), and the end byte of a message frame
// starts the acknowledge frame, followed by a payload store read and the
// delivered word for each payload byte, or by a single empty-message word.
// The pace is set by the microprogram step counter and the single read port
// of the payload store; a stall on the output holds the sequencer in place.
module stx_etx_frame_receiver_top
  import sefr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] msg_id_o,
  output logic [5:0] msg_size_o,
  output logic [4:0] payload_index_o,
  output logic [7:0] payload_byte_o,
  output logic       has_payload_o,
  output logic       last_o
);

  cfg_t   cfg_q;
  uword_t uw;
  stat_t  stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte              <= 8'd2;
      cfg_q.end_byte                <= 8'd3;
      cfg_q.type_message            <= 8'd0;
      cfg_q.type_acknowledge        <= 8'd1;
      cfg_q.type_discovery_request  <= 8'd2;
      cfg_q.type_discovery_response <= 8'd3;
      cfg_q.payload_limit           <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStart:    cfg_q.start_byte              <= cfg_wdata_i;
        RegEnd:      cfg_q.end_byte                <= cfg_wdata_i;
        RegTypeMsg:  cfg_q.type_message            <= cfg_wdata_i;
        RegTypeAck:  cfg_q.type_acknowledge        <= cfg_wdata_i;
        RegTypeDreq: cfg_q.type_discovery_request  <= cfg_wdata_i;
        RegTypeDrsp: cfg_q.type_discovery_response <= cfg_wdata_i;
        RegLimit:    cfg_q.payload_limit           <= cfg_wdata_i[5:0];
        default:     cfg_q                         <= cfg_q;
      endcase
    end
  end

  sefr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uw_o   (uw)
  );

  sefr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .uw_i            (uw),
    .stat_o          (stat),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_kind_o      (out_kind_o),
    .tx_byte_o       (tx_byte_o),
    .msg_id_o        (msg_id_o),
    .msg_size_o      (msg_size_o),
    .payload_index_o (payload_index_o),
    .payload_byte_o  (payload_byte_o),
    .has_payload_o   (has_payload_o),
    .last_o          (last_o)
  );

endmodule
